// ===== rtl/double_ended_queue_assert.svh =====
// Assertion macros used by the deque control, deq_ctrl.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/deq_pkg.sv =====
// Deque package: command and status codes, value width, control struct.
// No dependencies.
package deq_pkg;

    localparam int VALUE_W = 32;

    typedef logic [2:0] cmd_t;
    typedef logic [1:0] status_t;

    localparam cmd_t CMD_PUSH_FRONT = 3'd0;
    localparam cmd_t CMD_PUSH_BACK  = 3'd1;
    localparam cmd_t CMD_POP_FRONT  = 3'd2;
    localparam cmd_t CMD_POP_BACK   = 3'd3;
    localparam cmd_t CMD_CLEAR      = 3'd4;

    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_FULL  = 2'd1;
    localparam status_t STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic    load;
        logic    from_ram;
        status_t status;
    } rsp_ctl_t;

endpackage

// ===== rtl/deq_ram.sv =====
// Entry store of the deque: one write port, one read port, registered read data.
// Depends on deq_pkg.
module deq_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [deq_pkg::VALUE_W-1:0] wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [deq_pkg::VALUE_W-1:0] rdata
);

    logic [deq_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [deq_pkg::VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/deq_ctrl.sv =====
// Deque control: front pointer, element count, command decode, store access.
// Depends on deq_pkg and double_ended_queue_assert.svh.
`include "double_ended_queue_assert.svh"

module deq_ctrl #(
    parameter int DEPTH = 64,
    parameter int PTR_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  deq_pkg::cmd_t               cmd,
    input  logic [deq_pkg::VALUE_W-1:0] push_value,
    input  logic                        out_free,
    output logic                        we,
    output logic [PTR_W-1:0]            waddr,
    output logic [deq_pkg::VALUE_W-1:0] wdata,
    output logic                        re,
    output logic [PTR_W-1:0]            raddr,
    output deq_pkg::rsp_ctl_t           rsp,
    output logic [CNT_W-1:0]            rsp_count
);

    localparam int SUM_W = PTR_W + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic             state_reg, state_next;
    logic [PTR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             accept;
    logic             full, empty;
    logic [PTR_W-1:0] front_dec, front_inc;
    logic [SUM_W-1:0] back_sum, last_sum;
    logic [PTR_W-1:0] back_slot, last_slot;

    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    assign front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - PTR_W'(1);
    assign front_inc = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + PTR_W'(1);

    // ring offsets: front + count (next back slot), front + count - 1 (last entry)
    assign back_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign last_sum  = back_sum - SUM_W'(1);
    assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
                                                    : PTR_W'(back_sum);
    assign last_slot = (last_sum >= SUM_W'(DEPTH)) ? PTR_W'(last_sum - SUM_W'(DEPTH))
                                                    : PTR_W'(last_sum);

    always_comb
    begin
        state_next   = state_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        we           = 1'b0;
        waddr        = front_reg;
        wdata        = push_value;
        re           = 1'b0;
        raddr        = front_reg;
        rsp.load     = 1'b0;
        rsp.from_ram = 1'b0;
        rsp.status   = deq_pkg::STAT_OK;
        rsp_count    = count_reg;

        if (state_reg == S_READ)
        begin
            // read data for the pending pop is valid this cycle
            rsp.load     = 1'b1;
            rsp.from_ram = 1'b1;
            state_next   = S_IDLE;
        end
        else if (accept)
        begin
            rsp.load = 1'b1;
            unique case (cmd)
                deq_pkg::CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        rsp.status = deq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = front_dec;
                        front_next = front_dec;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                deq_pkg::CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        rsp.status = deq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = back_slot;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                deq_pkg::CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        rsp.status = deq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        re         = 1'b1;
                        raddr      = front_reg;
                        front_next = front_inc;
                        count_next = count_reg - CNT_W'(1);
                        rsp.load   = 1'b0;
                        state_next = S_READ;
                    end
                end
                deq_pkg::CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        rsp.status = deq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        re         = 1'b1;
                        raddr      = last_slot;
                        count_next = count_reg - CNT_W'(1);
                        rsp.load   = 1'b0;
                        state_next = S_READ;
                    end
                end
                deq_pkg::CMD_CLEAR:
                begin
                    front_next = '0;
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
            rsp_count = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    `DEQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH), "count above depth")
    `DEQ_ASSERT_IMP(a_front_bound, clk, rst_n, 1'b1, front_reg <= PTR_W'(DEPTH - 1), "front out of range")
    `DEQ_ASSERT_NXT(a_read_follow, clk, rst_n, re, state_reg == S_READ, "read without result cycle")
    `DEQ_ASSERT_IMP(a_read_stall, clk, rst_n, state_reg == S_READ, !in_ready && !we, "beat taken during read")
    `DEQ_ASSERT_NXT(a_pop_count, clk, rst_n, re, count_reg == $past(count_reg) - CNT_W'(1), "pop count slip")

endmodule

// ===== rtl/double_ended_queue.sv =====
// Bounded deque of signed 32-bit values in a DEPTH-entry ring store.
// Push, clear, no-op and refused pops: one beat per cycle while the output register is free, result registered.
// Successful pops: the registered store read is returned in a result state (S_READ) that takes no new beat.
// Reset (rst_n, async, active low) empties the deque and the output register.
// Depends on deq_pkg, deq_ctrl, deq_ram.
module double_ended_queue #(
    parameter int DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         cmd,
    input  logic signed [deq_pkg::VALUE_W-1:0] push_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [deq_pkg::VALUE_W-1:0] popped_value,
    output logic [1:0]                         status,
    output logic [$clog2(DEPTH + 1)-1:0]       element_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                        we, re;
    logic [PTR_W-1:0]            waddr, raddr;
    logic [deq_pkg::VALUE_W-1:0] wdata, rdata;
    deq_pkg::rsp_ctl_t           rsp;
    logic [CNT_W-1:0]            rsp_count;
    logic                        out_free;

    logic                        out_valid_reg;
    logic [deq_pkg::VALUE_W-1:0] value_reg;
    deq_pkg::status_t            status_reg;
    logic [CNT_W-1:0]            count_out_reg;

    assign out_free = !out_valid_reg || out_ready;

    deq_ctrl #(
        .DEPTH(DEPTH),
        .PTR_W(PTR_W),
        .CNT_W(CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .push_value(push_value),
        .out_free  (out_free),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .re        (re),
        .raddr     (raddr),
        .rsp       (rsp),
        .rsp_count (rsp_count)
    );

    deq_ram #(
        .DEPTH (DEPTH),
        .ADDR_W(PTR_W)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp.load)
        begin
            value_reg     <= rsp.from_ram ? rdata : '0;
            status_reg    <= rsp.status;
            count_out_reg <= rsp_count;
        end
    end

    assign out_valid     = out_valid_reg;
    assign popped_value  = $signed(value_reg);
    assign status        = status_reg;
    assign element_count = count_out_reg;

endmodule
